[hdl/kid_pkg.sv]
package kid_pkg;

    // Window geometry
    localparam int WINDOW        = 32;
    localparam int INTERVAL_BITS = 24;
    localparam int PTR_BITS      = $clog2(WINDOW);
    localparam int FILL_BITS     = $clog2(WINDOW + 1);
    localparam int SUM_BITS      = INTERVAL_BITS + $clog2(WINDOW);

    // Field widths
    localparam int KEY_BITS  = 8;
    localparam int PAIR_BITS = 2 * KEY_BITS;
    localparam int HIT_BITS  = 2;

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SPEED_LIMIT = 3'd0,
        CFG_MONITOR     = 3'd1,
        CFG_PAIR_A      = 3'd2,
        CFG_PAIR_B      = 3'd3,
        CFG_PAIR_C      = 3'd4
    } t_cfg_idx;

    // Register reset values
    localparam logic [INTERVAL_BITS-1:0] SPEED_LIMIT_RST = INTERVAL_BITS'(26000);
    localparam logic [PAIR_BITS-1:0]     PAIR_A_RST      = 16'h5B52;
    localparam logic [PAIR_BITS-1:0]     PAIR_B_RST      = 16'h5B28;
    localparam logic [PAIR_BITS-1:0]     PAIR_C_RST      = 16'hA473;

    // Which pair matched
    typedef enum logic [HIT_BITS-1:0] {
        HIT_PAIR_A = 2'd0,
        HIT_PAIR_B = 2'd1,
        HIT_PAIR_C = 2'd2
    } t_hit;

    typedef struct packed {
        logic [INTERVAL_BITS-1:0] speed_limit;
        logic                     monitor_only;
        logic [PAIR_BITS-1:0]     pair_a;
        logic [PAIR_BITS-1:0]     pair_b;
        logic [PAIR_BITS-1:0]     pair_c;
    } t_cfg;

    // Pipeline control from the top level
    typedef struct packed {
        logic rd;      // key item accepted: read its ring entry
        logic wr_key;  // key item leaves the read stage
        logic clr;     // clear tick leaves the read stage
    } t_ctl;

    typedef struct packed {
        logic                     flag;
        logic                     alert;
        logic [INTERVAL_BITS-1:0] mean;
        logic                     mean_valid;
    } t_speed_res;

    typedef struct packed {
        logic flag;
        logic alert;
        t_hit hit;
    } t_pat_res;

endpackage

[hdl/kid_ram.sv]
module kid_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/kid_window.sv]
module kid_window (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  kid_pkg::t_ctl                     i_ctl,
    input  logic [kid_pkg::INTERVAL_BITS-1:0] i_ival,
    input  kid_pkg::t_cfg                     i_cfg,
    output kid_pkg::t_speed_res               o_res
);
    import kid_pkg::*;

    logic [PTR_BITS-1:0]      r_ptr;
    logic [PTR_BITS-1:0]      r_addr;
    logic [FILL_BITS-1:0]     r_fill;
    logic [SUM_BITS-1:0]      r_sum;
    logic                     r_speed;
    logic [INTERVAL_BITS-1:0] rd_data;
    logic [INTERVAL_BITS-1:0] old_ival;
    logic                     full;
    logic [INTERVAL_BITS-1:0] mean;
    logic                     alert;

    // Ring of intervals
    kid_ram #(
        .WIDTH (INTERVAL_BITS),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_key),
        .i_waddr (r_addr),
        .i_wdata (i_ival),
        .i_re    (i_ctl.rd),
        .i_raddr (r_ptr),
        .o_rdata (rd_data)
    );

    // Entries past the fill count were never written and are taken as zero
    assign full     = (r_fill == FILL_BITS'(WINDOW));
    assign old_ival = full ? rd_data : '0;
    assign mean     = INTERVAL_BITS'(r_sum / WINDOW);
    assign alert    = i_ctl.wr_key && full && !r_speed && (mean < i_cfg.speed_limit);

    // Read pointer advances as key items enter; address follows the item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_ctl.rd) begin
            r_ptr <= (r_ptr == PTR_BITS'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_addr <= r_ptr;
        end
    end

    // Running sum, fill count and sticky speed flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_sum   <= '0;
            r_speed <= 1'b0;
        end else if (i_ctl.clr) begin
            r_speed <= 1'b0;
        end else if (i_ctl.wr_key) begin
            r_sum <= r_sum - SUM_BITS'(old_ival) + SUM_BITS'(i_ival);
            if (!full) begin
                r_fill <= r_fill + 1'b1;
            end
            if (alert) begin
                r_speed <= 1'b1;
            end
        end
    end

    always_comb begin
        o_res.flag       = !i_ctl.clr && (r_speed || alert);
        o_res.alert      = alert;
        o_res.mean       = (i_ctl.wr_key && full) ? mean : '0;
        o_res.mean_valid = i_ctl.wr_key && full;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_BITS'(WINDOW))
        else $error("fill count beyond window");

    a_clr_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clr |=> !r_speed)
        else $error("speed flag survived a clear");

endmodule

[hdl/kid_pattern.sv]
module kid_pattern (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  kid_pkg::t_ctl                i_ctl,
    input  logic [kid_pkg::KEY_BITS-1:0] i_key,
    input  kid_pkg::t_cfg                i_cfg,
    output kid_pkg::t_pat_res            o_res
);
    import kid_pkg::*;

    logic [KEY_BITS-1:0] r_last;
    logic                r_last_vld;
    logic                r_pattern;
    logic                m_a;
    logic                m_b;
    logic                m_c;
    logic                hit;
    t_hit                hit_code;

    // Compare previous and current key against each pair
    assign m_a = (i_cfg.pair_a == {r_last, i_key});
    assign m_b = (i_cfg.pair_b == {r_last, i_key});
    assign m_c = (i_cfg.pair_c == {r_last, i_key});
    assign hit = i_ctl.wr_key && !i_cfg.monitor_only && r_last_vld && !r_pattern
                 && (m_a || m_b || m_c);

    // Lowest matching pair wins
    always_comb begin
        if (!hit || m_a) begin
            hit_code = HIT_PAIR_A;
        end else if (m_b) begin
            hit_code = HIT_PAIR_B;
        end else begin
            hit_code = HIT_PAIR_C;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= '0;
            r_last_vld <= 1'b0;
            r_pattern  <= 1'b0;
        end else if (i_ctl.clr) begin
            r_pattern <= 1'b0;
        end else if (i_ctl.wr_key) begin
            if (i_cfg.monitor_only) begin
                r_last_vld <= 1'b0;
            end else begin
                r_last     <= i_key;
                r_last_vld <= 1'b1;
                if (hit) begin
                    r_pattern <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        o_res.flag  = !i_ctl.clr && (r_pattern || hit);
        o_res.alert = hit;
        o_res.hit   = hit_code;
    end

    a_hit_needs_alert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.hit != HIT_PAIR_A) |-> o_res.alert)
        else $error("pair code without pattern alert");

endmodule

[hdl/keystroke_injection_detector.sv]
// Keystroke injection detector. Each input item is a key-down (tuser 0) carrying a key
// code and the interval since the previous key, or a clear tick (tuser 1) that drops
// both sticky flags. Every item gives exactly one result item. The block takes one item
// per clock cycle when the output side keeps up; an item waits in the read stage for the
// registered read of the interval ring, and its result is held in the output register.
// The throughput is set by the ring memory, which serves one read and one write per
// cycle. The user must write configuration registers through i_cfg_we, i_cfg_idx and
// i_cfg_data only while no item is in flight; the block itself does not enforce this.
module keystroke_injection_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,  // key_code, interval_us
    input  logic [0:0]                        s_axis_tuser,  // mode
    // master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // speed_flag, pattern_flag,
                                                             // speed_alert, pattern_alert,
                                                             // pair_hit, mean_us,
                                                             // mean_valid
    // configuration
    input  logic                              i_cfg_we,
    input  logic [kid_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [kid_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import kid_pkg::*;

    t_cfg                     r_cfg;
    logic                     r_s1_vld;
    logic                     r_s1_mode;
    logic [KEY_BITS-1:0]      r_s1_key;
    logic [INTERVAL_BITS-1:0] r_s1_ival;
    logic                     r_out_vld;
    logic [31:0]              r_out_data;
    logic                     s_acc;
    logic                     s1_fire;
    t_ctl                     ctl;
    t_speed_res               speed_res;
    t_pat_res                 pat_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_limit  <= SPEED_LIMIT_RST;
            r_cfg.monitor_only <= 1'b0;
            r_cfg.pair_a       <= PAIR_A_RST;
            r_cfg.pair_b       <= PAIR_B_RST;
            r_cfg.pair_c       <= PAIR_C_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SPEED_LIMIT: r_cfg.speed_limit  <= i_cfg_data[INTERVAL_BITS-1:0];
                CFG_MONITOR:     r_cfg.monitor_only <= i_cfg_data[0];
                CFG_PAIR_A:      r_cfg.pair_a       <= i_cfg_data[PAIR_BITS-1:0];
                CFG_PAIR_B:      r_cfg.pair_b       <= i_cfg_data[PAIR_BITS-1:0];
                CFG_PAIR_C:      r_cfg.pair_c       <= i_cfg_data[PAIR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Handshakes
    assign s1_fire       = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || s1_fire;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_comb begin
        ctl.rd     = s_acc && !s_axis_tuser[0];
        ctl.wr_key = s1_fire && !r_s1_mode;
        ctl.clr    = s1_fire && r_s1_mode;
    end

    // Read stage: item waits here while its ring entry is read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_mode <= s_axis_tuser[0];
            r_s1_key  <= s_axis_tdata[KEY_BITS-1:0];
            r_s1_ival <= s_axis_tdata[KEY_BITS +: INTERVAL_BITS];
        end
    end

    kid_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_ival  (r_s1_ival),
        .i_cfg   (r_cfg),
        .o_res   (speed_res)
    );

    kid_pattern u_pattern (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_key   (r_s1_key),
        .i_cfg   (r_cfg),
        .o_res   (pat_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_data <= {1'b0, speed_res.mean_valid, speed_res.mean, pat_res.hit,
                           pat_res.alert, speed_res.alert, pat_res.flag, speed_res.flag};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_fire) |=> r_s1_vld)
        else $error("item dropped from read stage");

    a_speed_alert_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_data[2]) |-> r_out_data[0])
        else $error("speed alert without speed flag");

endmodule
